// File: hdl/http_request_framer_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the HTTP request framer.
// Every macro samples on aclk and is disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef HTTP_REQUEST_FRAMER_TOP_ASSERT_SVH
`define HTTP_REQUEST_FRAMER_TOP_ASSERT_SVH

// Same-cycle implication.
`define HRF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/hrf_pkg.sv
// ---------------------------------------------------------------------------
// hrf_pkg
// Types, codes and match strings shared by the HTTP request framer.
// ---------------------------------------------------------------------------
`default_nettype none

package hrf_pkg;

    localparam int COUNT_WIDTH = 20;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Length of "content-length: "
    localparam logic [4:0] NAME_LEN = 5'd16;

    // Byte roles
    localparam logic [1:0] ROLE_HEADER = 2'd0;
    localparam logic [1:0] ROLE_URL    = 2'd1;
    localparam logic [1:0] ROLE_BODY   = 2'd2;

    // Method codes
    localparam logic [1:0] METHOD_GET    = 2'd0;
    localparam logic [1:0] METHOD_POST   = 2'd1;
    localparam logic [1:0] METHOD_DELETE = 2'd2;

    // Characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_C = 8'h63;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum logic [1:0] {
        DIG_WAIT,
        DIG_NUMBER,
        DIG_DONE
    } hrf_digit_phase_t;

    typedef struct packed {
        logic       start_of_request;
        logic [7:0] data_byte;
    } hrf_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] byte_role;
        logic [1:0] method_code;
        logic       headers_done;
        logic       length_seen;
        logic       request_complete;
    } hrf_out_t;

    // "content-length: ", lower case
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3A; // :
            default: c = 8'h20; // space
        endcase
        return c;
    endfunction

    // "POST"
    function automatic logic [7:0] post_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h50;
            2'd1:    c = 8'h4F;
            2'd2:    c = 8'h53;
            default: c = 8'h54;
        endcase
        return c;
    endfunction

    // "DELETE"
    function automatic logic [7:0] delete_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h44;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h4C;
            3'd3:    c = 8'h45;
            3'd4:    c = 8'h54;
            default: c = 8'h45;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hdl/hrf_byte_parser.sv
// ---------------------------------------------------------------------------
// hrf_byte_parser
// Per-byte parse state and the result for the byte being taken.
// ---------------------------------------------------------------------------
`default_nettype none

module hrf_byte_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire hrf_pkg::hrf_in_t  in_item,
    output hrf_pkg::hrf_out_t      result
);
    import hrf_pkg::*;

    logic [2:0]             blank_reg,     blank_next;
    logic [4:0]             name_prog_reg, name_prog_next;
    logic                   len_found_reg, len_found_next;
    hrf_digit_phase_t       digit_reg,     digit_next;
    logic                   len_neg_reg,   len_neg_next;
    logic [COUNT_WIDTH-1:0] decl_len_reg,  decl_len_next;
    logic [COUNT_WIDTH-1:0] body_cnt_reg,  body_cnt_next;
    logic                   hdr_end_reg,   hdr_end_next;
    logic [2:0]             meth_prog_reg, meth_prog_next;
    logic [1:0]             meth_st_reg,   meth_st_next;
    logic [1:0]             space_reg,     space_next;

    // State as seen by this byte: a start mark restarts from reset values
    logic [2:0]             cur_blank;
    logic [4:0]             cur_name_prog;
    logic                   cur_len_found;
    hrf_digit_phase_t       cur_digit;
    logic                   cur_len_neg;
    logic [COUNT_WIDTH-1:0] cur_decl_len;
    logic [COUNT_WIDTH-1:0] cur_body_cnt;
    logic                   cur_hdr_end;
    logic [2:0]             cur_meth_prog;
    logic [1:0]             cur_meth_st;
    logic [1:0]             cur_space;

    logic [7:0]             b;
    logic [7:0]             low;
    logic                   is_digit;
    logic                   is_ws;
    logic                   is_sign;
    logic [COUNT_WIDTH+3:0] times_ten;
    hrf_digit_phase_t       digit_parse;
    logic [1:0]             role;
    logic [1:0]             code;
    logic [COUNT_WIDTH-1:0] eff_len;

    assign b        = in_item.data_byte;
    assign low      = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_OFFSET : b;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_ws    = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    assign is_sign  = (b == CH_PLUS) || (b == CH_MINUS);

    always_comb begin
        if (in_item.start_of_request) begin
            cur_blank     = '0;
            cur_name_prog = '0;
            cur_len_found = 1'b0;
            cur_digit     = DIG_WAIT;
            cur_len_neg   = 1'b0;
            cur_decl_len  = '0;
            cur_body_cnt  = '0;
            cur_hdr_end   = 1'b0;
            cur_meth_prog = '0;
            cur_meth_st   = 2'b11;
            cur_space     = '0;
        end else begin
            cur_blank     = blank_reg;
            cur_name_prog = name_prog_reg;
            cur_len_found = len_found_reg;
            cur_digit     = digit_reg;
            cur_len_neg   = len_neg_reg;
            cur_decl_len  = decl_len_reg;
            cur_body_cnt  = body_cnt_reg;
            cur_hdr_end   = hdr_end_reg;
            cur_meth_prog = meth_prog_reg;
            cur_meth_st   = meth_st_reg;
            cur_space     = space_reg;
        end
    end

    // Value parse phase: wait (skip white space), in number, done
    always_comb begin
        digit_parse = cur_digit;
        if (cur_len_found) begin
            case (cur_digit)
                DIG_WAIT: begin
                    if (is_digit || is_sign) begin
                        digit_parse = DIG_NUMBER;
                    end else if (!is_ws) begin
                        digit_parse = DIG_DONE;
                    end
                end
                DIG_NUMBER: begin
                    if (!is_digit) begin
                        digit_parse = DIG_DONE;
                    end
                end
                default: digit_parse = cur_digit;
            endcase
        end
    end

    // v*10 + digit, one extra nibble of headroom for the saturation check
    assign times_ten = ({4'd0, cur_decl_len} << 3) + ({4'd0, cur_decl_len} << 1)
                     + {{(COUNT_WIDTH){1'b0}}, b[3:0] - CH_ZERO[3:0]};

    always_comb begin
        // role from state before this byte
        if (cur_hdr_end) begin
            role = ROLE_BODY;
        end else if (cur_space == 2'd1 && b != CH_SPACE) begin
            role = ROLE_URL;
        end else begin
            role = ROLE_HEADER;
        end

        // method match
        meth_st_next = cur_meth_st;
        if (cur_meth_prog < 3'd6) begin
            if (cur_meth_prog < 3'd4 && b != post_char(cur_meth_prog[1:0])) begin
                meth_st_next[0] = 1'b0;
            end
            if (b != delete_char(cur_meth_prog)) begin
                meth_st_next[1] = 1'b0;
            end
        end
        meth_prog_next = (cur_meth_prog != 3'd7) ? cur_meth_prog + 3'd1 : cur_meth_prog;
        if (meth_st_next[0] && meth_prog_next >= 3'd4) begin
            code = METHOD_POST;
        end else if (meth_st_next[1] && meth_prog_next >= 3'd6) begin
            code = METHOD_DELETE;
        end else begin
            code = METHOD_GET;
        end

        space_next = (b == CH_SPACE && cur_space < 2'd2) ? cur_space + 2'd1 : cur_space;

        // number value
        decl_len_next = cur_decl_len;
        len_neg_next  = cur_len_neg;
        if (cur_len_found && cur_digit != DIG_DONE) begin
            if (is_digit) begin
                decl_len_next = (times_ten[COUNT_WIDTH+3:COUNT_WIDTH] != 4'd0)
                              ? COUNT_MAX : times_ten[COUNT_WIDTH-1:0];
            end else if (cur_digit == DIG_WAIT && is_sign) begin
                len_neg_next = (b == CH_MINUS);
            end
        end
        digit_next = digit_parse;

        // header name match, only before the end of headers
        name_prog_next = cur_name_prog;
        len_found_next = cur_len_found;
        if (!cur_hdr_end && !cur_len_found) begin
            if (low == name_char(cur_name_prog[3:0])) begin
                name_prog_next = cur_name_prog + 5'd1;
            end else begin
                name_prog_next = (low == CH_LOWER_C) ? 5'd1 : 5'd0;
            end
            if (name_prog_next >= NAME_LEN) begin
                name_prog_next = NAME_LEN;
                len_found_next = 1'b1;
                digit_next     = DIG_WAIT;
            end
        end

        // CR LF CR LF
        blank_next   = cur_blank;
        hdr_end_next = cur_hdr_end;
        if (!cur_hdr_end) begin
            if (b == CH_CR) begin
                blank_next = (cur_blank == 3'd2) ? 3'd3 : 3'd1;
            end else if (b == CH_LF && cur_blank == 3'd1) begin
                blank_next = 3'd2;
            end else if (b == CH_LF && cur_blank == 3'd3) begin
                blank_next   = 3'd4;
                hdr_end_next = 1'b1;
            end else begin
                blank_next = 3'd0;
            end
        end

        body_cnt_next = (role == ROLE_BODY && cur_body_cnt != COUNT_MAX)
                      ? cur_body_cnt + 1'b1 : cur_body_cnt;
    end

    assign eff_len = len_neg_next ? '0 : decl_len_next;

    always_comb begin
        result.out_byte         = b;
        result.byte_role        = role;
        result.method_code      = code;
        result.headers_done     = hdr_end_next;
        result.length_seen      = len_found_next;
        result.request_complete = hdr_end_next
                                && (!len_found_next || body_cnt_next >= eff_len);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blank_reg     <= '0;
            name_prog_reg <= '0;
            len_found_reg <= 1'b0;
            digit_reg     <= DIG_WAIT;
            len_neg_reg   <= 1'b0;
            decl_len_reg  <= '0;
            body_cnt_reg  <= '0;
            hdr_end_reg   <= 1'b0;
            meth_prog_reg <= '0;
            meth_st_reg   <= 2'b11;
            space_reg     <= '0;
        end else if (step_en) begin
            blank_reg     <= blank_next;
            name_prog_reg <= name_prog_next;
            len_found_reg <= len_found_next;
            digit_reg     <= digit_next;
            len_neg_reg   <= len_neg_next;
            decl_len_reg  <= decl_len_next;
            body_cnt_reg  <= body_cnt_next;
            hdr_end_reg   <= hdr_end_next;
            meth_prog_reg <= meth_prog_next;
            meth_st_reg   <= meth_st_next;
            space_reg     <= space_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/http_request_framer_top.sv
// ---------------------------------------------------------------------------
// http_request_framer_top
// Byte-serial HTTP request framer: tags each byte with its role, the
// method, header end, content-length presence and request completion.
// ---------------------------------------------------------------------------
//  Channel | Ports                          | Direction | Content
//  --------+--------------------------------+-----------+----------------------
//  s_      | s_valid, s_ready, s_payload    | in        | start mark, raw byte
//  m_      | m_valid, m_ready, m_payload    | out       | byte and its tags
//
//  One transfer in and one transfer out per byte; a byte can be taken every
//  cycle unless m_ stalls; each result is held in the single result register.
//  s_ready stays high while the result register is empty or is being drained
//  in the same cycle, so a stall on m_ stalls s_ only while a result waits.
//  aresetn is synchronous; s_ready is held low after it until run_reg is set.
// ---------------------------------------------------------------------------
`default_nettype none

module http_request_framer_top (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output      logic              s_ready,
    input  wire hrf_pkg::hrf_in_t  s_payload,
    output      logic              m_valid,
    input  wire logic              m_ready,
    output      hrf_pkg::hrf_out_t m_payload
);
    import hrf_pkg::*;

    logic     run_reg;      // high once reset has been released
    logic     m_valid_reg;
    hrf_out_t result_reg;
    hrf_out_t result_next;
    logic     s_fire;

    // Take a new byte when the result register is free or drains this cycle
    assign s_ready = run_reg && (!m_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;

    // Parse state lives in the parser and advances on each input transfer
    hrf_byte_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (s_fire),
        .in_item (s_payload),
        .result  (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            run_reg <= 1'b1;
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            result_reg <= result_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = result_reg;

endmodule

`default_nettype wire

// File: hdl/hrf_port_checker.sv
// ---------------------------------------------------------------------------
// hrf_port_checker
// Port-level checks for the HTTP request framer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "http_request_framer_top_assert.svh"

module hrf_port_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire hrf_pkg::hrf_in_t  s_payload,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire hrf_pkg::hrf_out_t m_payload
);
    import hrf_pkg::*;

    // A stalled result holds
    `HRF_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_payload), "result dropped")

    // Empty result register means the input side is open
    `HRF_ASSERT_NOW(a_ready, !m_valid && $past(aresetn), s_ready, "ready low while empty")

    // Every input transfer shows up as the next result, byte passed through
    `HRF_ASSERT_NEXT(a_pass, s_valid && s_ready, m_valid && m_payload.out_byte == $past(s_payload.data_byte), "byte lost")

    // Body bytes and completion only after the headers ended
    `HRF_ASSERT_NOW(a_body, m_valid && (m_payload.byte_role == ROLE_BODY || m_payload.request_complete), m_payload.headers_done, "body before header end")

endmodule

bind http_request_framer_top hrf_port_checker u_port_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

`default_nettype wire
